/* hdl/bhs_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bhs_pkg
// Shared types and constants for the bitap Hamming-distance search block.
// ============================================================================
package bhs_pkg;

    localparam int MAX_MISMATCHES_DEF = 7;
    localparam int PATTERN_MAX        = 31;
    localparam int ROW_W              = 32;
    localparam int PATTERN_REGS       = 4;
    localparam int PATTERN_REG_W      = 64;
    localparam int BYTE_W             = 8;
    localparam int LEN_W              = 5;
    localparam int K_W                = 3;
    localparam int POS_W              = 32;
    localparam int APB_DATA_W         = 64;
    localparam int APB_ADDR_W         = 6;
    localparam int REG_SEL_LSB        = 3;

    localparam logic [ROW_W-1:0] ROW_INIT = 32'hFFFF_FFFE;

    typedef enum logic [APB_ADDR_W-REG_SEL_LSB-1:0] {
        REG_PATTERN_0,
        REG_PATTERN_1,
        REG_PATTERN_2,
        REG_PATTERN_3,
        REG_PATTERN_LENGTH,
        REG_MAX_MISMATCHES
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_start;
    } text_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] match_start;
        logic             already_found;
    } result_t;

    typedef struct packed {
        logic [PATTERN_REGS*PATTERN_REG_W-1:0] pattern;
        logic [LEN_W-1:0]                      length;
        logic [K_W-1:0]                        mismatches;
    } cfg_t;

    typedef struct packed {
        logic             text_start;
        logic [ROW_W-1:0] mask;
    } mask_req_t;

endpackage

/* hdl/bhs_cfg_regs.sv */
`timescale 1ns / 1ps
// ============================================================================
// bhs_cfg_regs
// APB register file holding the pattern bytes, pattern length and the
// allowed number of substitutions.
// ============================================================================
module bhs_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bhs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bhs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bhs_pkg::APB_DATA_W-1:0]     prdata,
    output bhs_pkg::cfg_t                      cfg
);
    import bhs_pkg::*;

    logic [PATTERN_REGS-1:0][PATTERN_REG_W-1:0] pattern_reg;
    logic [LEN_W-1:0]                           length_reg;
    logic [K_W-1:0]                             mismatch_reg;
    logic                                       write_en;
    reg_index_t                                 reg_sel;

    assign write_en = psel && penable && pwrite;
    assign reg_sel  = reg_index_t'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            length_reg   <= LEN_W'(1);
            mismatch_reg <= '0;
        end
        else if (write_en)
        begin
            case (reg_sel)
                REG_PATTERN_0:      pattern_reg[0] <= pwdata;
                REG_PATTERN_1:      pattern_reg[1] <= pwdata;
                REG_PATTERN_2:      pattern_reg[2] <= pwdata;
                REG_PATTERN_3:      pattern_reg[3] <= pwdata;
                REG_PATTERN_LENGTH: length_reg     <= pwdata[LEN_W-1:0];
                REG_MAX_MISMATCHES: mismatch_reg   <= pwdata[K_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PATTERN_0:      prdata = pattern_reg[0];
            REG_PATTERN_1:      prdata = pattern_reg[1];
            REG_PATTERN_2:      prdata = pattern_reg[2];
            REG_PATTERN_3:      prdata = pattern_reg[3];
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(length_reg);
            REG_MAX_MISMATCHES: prdata = APB_DATA_W'(mismatch_reg);
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.pattern    = pattern_reg;
        cfg.mismatches = mismatch_reg;
        if (32'(length_reg) > 32'(PATTERN_MAX))
        begin
            cfg.length = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            cfg.length = length_reg;
        end
    end

endmodule

/* hdl/bhs_mask_stage.sv */
`timescale 1ns / 1ps
// ============================================================================
// bhs_mask_stage
// Input register stage that compares each text byte against each pattern
// byte below the configured length and registers the resulting match mask.
// ============================================================================
module bhs_mask_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_ready,
    input  bhs_pkg::text_t      text,
    input  bhs_pkg::cfg_t       cfg,
    output logic                req_valid,
    output bhs_pkg::mask_req_t  req,
    input  logic                core_ready
);
    import bhs_pkg::*;

    logic      s1_valid_reg;
    mask_req_t req_reg;
    mask_req_t req_next;

    assign text_ready = !s1_valid_reg || core_ready;
    assign req_valid  = s1_valid_reg;
    assign req        = req_reg;

    always_comb
    begin
        req_next.text_start = text.text_start;
        req_next.mask       = '1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((LEN_W'(i) < cfg.length) &&
                (cfg.pattern[BYTE_W*i +: BYTE_W] == text.text_byte))
            begin
                req_next.mask[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text_ready)
        begin
            s1_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            req_reg <= req_next;
        end
    end

endmodule

/* hdl/bhs_match_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// bhs_match_core
// Mismatch row state, position counter and found flag, updated once per
// text byte, with the registered result.
// ============================================================================
module bhs_match_core #(
    parameter int MAX_MISMATCHES = bhs_pkg::MAX_MISMATCHES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  bhs_pkg::mask_req_t  req,
    input  bhs_pkg::cfg_t       cfg,
    output logic                core_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output bhs_pkg::result_t    result
);
    import bhs_pkg::*;

    localparam int ROW_COUNT = MAX_MISMATCHES + 1;
    localparam int ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    logic [ROW_W-1:0]     rows_reg   [ROW_COUNT];
    logic [ROW_W-1:0]     rows_cur   [ROW_COUNT];
    logic [ROW_W-1:0]     rows_shift [ROW_COUNT];
    logic [ROW_W-1:0]     rows_next  [ROW_COUNT];
    logic                 found_reg;
    logic                 found_cur;
    logic                 found_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_cur;
    logic [POS_W-1:0]     pos_inc;
    logic [POS_W-1:0]     pos_next;
    logic [POS_W:0]       end_pos;
    logic [POS_W:0]       len_ext;
    logic [POS_W-1:0]     start_pos;
    logic [ROW_IDX_W-1:0] k_sel;
    logic                 match;
    logic                 result_valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic                 step;

    assign core_ready   = !result_valid_reg || result_ready;
    assign step         = req_valid && core_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        for (int d = 0; d < ROW_COUNT; d++)
        begin
            rows_cur[d] = req.text_start ? ROW_INIT : rows_reg[d];
        end
        rows_shift[0] = (rows_cur[0] | req.mask) << 1;
        for (int d = 1; d < ROW_COUNT; d++)
        begin
            rows_shift[d] = (rows_cur[d-1] & (rows_cur[d] | req.mask)) << 1;
        end
    end

    always_comb
    begin
        if (32'(cfg.mismatches) > 32'(MAX_MISMATCHES))
        begin
            k_sel = ROW_IDX_W'(MAX_MISMATCHES);
        end
        else
        begin
            k_sel = ROW_IDX_W'(cfg.mismatches);
        end
    end

    assign found_cur = !req.text_start && found_reg;
    assign pos_cur   = req.text_start ? '0 : pos_reg;
    assign pos_inc   = (&pos_cur) ? pos_cur : pos_cur + POS_W'(1);
    assign end_pos   = {1'b0, pos_cur} + (POS_W+1)'(1);
    assign len_ext   = (POS_W+1)'(cfg.length);
    assign start_pos = (end_pos >= len_ext) ? POS_W'(end_pos - len_ext) : '0;
    assign match     = !rows_shift[k_sel][cfg.length];

    always_comb
    begin
        rows_next   = rows_cur;
        found_next  = found_cur;
        pos_next    = pos_cur;
        result_next = '0;
        if (found_cur)
        begin
            result_next.already_found = 1'b1;
        end
        else if (cfg.length == '0)
        begin
            found_next      = 1'b1;
            pos_next        = pos_inc;
            result_next.hit = 1'b1;
        end
        else
        begin
            rows_next = rows_shift;
            pos_next  = pos_inc;
            if (match)
            begin
                found_next              = 1'b1;
                result_next.hit         = 1'b1;
                result_next.match_start = start_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < ROW_COUNT; d++)
            begin
                rows_reg[d] <= ROW_INIT;
            end
            found_reg        <= 1'b0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                rows_reg  <= rows_next;
                found_reg <= found_next;
                pos_reg   <= pos_next;
            end
            if (core_ready)
            begin
                result_valid_reg <= req_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* hdl/bitap_hamming_search_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// bitap_hamming_search_top
// The block returns one result per accepted text byte. The mask stage
// registers the byte's match mask against the pattern bytes below the
// configured length; the core then updates the MAX_MISMATCHES+1 mismatch
// rows in parallel and registers the result. Its update of rows, position
// and found flag is the only loop that carries state from byte to byte,
// so the sustained rate is one byte per cycle whenever the result side
// keeps taking results. A request with text_start set begins a new text.
// Each text reports its first match at most once, with the offset of the
// match start; later bytes of that text return already_found. The APB
// configuration registers sit at byte address 8*i; the user writes them
// only while no request is in flight, which the block does not enforce.
// ============================================================================
module bitap_hamming_search_top #(
    parameter int MAX_MISMATCHES = bhs_pkg::MAX_MISMATCHES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bhs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bhs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bhs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  bhs_pkg::text_t                 text,
    output logic                           result_valid,
    input  logic                           result_ready,
    output bhs_pkg::result_t               result
);
    import bhs_pkg::*;

    cfg_t      cfg;
    mask_req_t req;
    logic      req_valid;
    logic      core_ready;

    assign pready = 1'b1;

    bhs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bhs_mask_stage u_mask_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req        (req),
        .core_ready (core_ready)
    );

    bhs_match_core #(
        .MAX_MISMATCHES (MAX_MISMATCHES)
    ) u_match_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req          (req),
        .cfg          (cfg),
        .core_ready   (core_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_hit_found_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.hit && result.already_found))
        else $error("Result reports a hit and an ignored byte at once.");

    a_start_zero_without_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.hit) |-> (result.match_start == '0))
        else $error("Match start is nonzero on a result without a hit.");

    a_full_pipe_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && result_valid && !result_ready) |-> !text_ready)
        else $error("Input accepted while both stages are full and stalled.");

endmodule

/* test/bitap_hamming_search_top_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// bitap_hamming_search_top_tb
// Self-checking bench for the bitap Hamming-distance search block. A local
// copy of the row update predicts one result per text request. Patterns,
// lengths and mismatch limits change over several phases. Directed texts
// come first, then random texts with planted, damaged and noisy matches,
// under random sender gaps, receiver stalls and back-pressure.
// ============================================================================
module bitap_hamming_search_top_tb;

    import bhs_pkg::*;

    localparam int ROWS = MAX_MISMATCHES_DEF + 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  text_valid = 1'b0;
    logic                  text_ready;
    text_t                 text = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;

    logic [PATTERN_REG_W-1:0] cfg_pattern [0:PATTERN_REGS-1];
    logic [LEN_W-1:0]         cfg_length;
    logic [K_W-1:0]           cfg_k;
    logic [ROW_W-1:0]         search_rows [0:ROWS-1];
    logic                     text_found;
    logic [POS_W-1:0]         text_pos;

    result_t pending_results [$];
    result_t want;
    int      error_count = 0;
    int      sent_count = 0;
    int      burst_left = 0;
    bit      sender_gaps = 1'b1;
    bit      receiver_stalls = 1'b1;
    int      hold_request = 0;
    int      hold_left = 0;
    int      stall_run = 0;
    bit      ready_phase = 1'b0;
    bit      small_alpha = 1'b0;
    logic [BYTE_W-1:0] alpha_base = '0;

    bitap_hamming_search_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text         (text),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("bitap_hamming_search_top test failed");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
        return cfg_pattern[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic void clear_text_state();
        for (int d = 0; d < ROWS; d++)
            search_rows[d] = ROW_INIT;
        text_found = 1'b0;
        text_pos = '0;
    endfunction

    function automatic result_t predict_result(input text_t t);
        result_t          r;
        logic [ROW_W-1:0] mask;
        logic [ROW_W-1:0] prev;
        logic [ROW_W-1:0] cur;
        logic [POS_W-1:0] pos;
        logic [POS_W:0]   end_pos;
        int               m;
        r = '0;
        if (t.text_start)
            clear_text_state();
        if (text_found)
        begin
            r.already_found = 1'b1;
            return r;
        end
        m = int'(cfg_length);
        pos = text_pos;
        if (text_pos != '1)
            text_pos = text_pos + 1;
        if (m == 0)
        begin
            text_found = 1'b1;
            r.hit = 1'b1;
            return r;
        end
        mask = '1;
        for (int i = 0; i < m; i++)
            if (pattern_byte(i) == t.text_byte)
                mask[i] = 1'b0;
        prev = search_rows[0];
        search_rows[0] = (search_rows[0] | mask) << 1;
        for (int d = 1; d < ROWS; d++)
        begin
            cur = search_rows[d];
            search_rows[d] = (prev & (cur | mask)) << 1;
            prev = cur;
        end
        if (!search_rows[cfg_k][m])
        begin
            end_pos = {1'b0, pos} + 1;
            r.hit = 1'b1;
            r.match_start = (end_pos >= m) ? POS_W'(end_pos - m) : '0;
            text_found = 1'b1;
        end
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            if (stall_run == 0)
            begin
                ready_phase = !receiver_stalls || ($urandom_range(0, 9) < 7);
                stall_run = $urandom_range(1, 8);
            end
            result_ready <= ready_phase;
            stall_run--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none pending, actual %p", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, result.hit);
                    error_count++;
                end
                if (result.match_start !== want.match_start)
                begin
                    $display("%0t: match_start expected %0d actual %0d",
                             $time, want.match_start, result.match_start);
                    error_count++;
                end
                if (result.already_found !== want.already_found)
                begin
                    $display("%0t: already_found expected %0b actual %0b",
                             $time, want.already_found, result.already_found);
                    error_count++;
                end
            end
        end
    end

    task automatic send_text(input logic [BYTE_W-1:0] b, input logic s);
        text_t t;
        int    gap;
        t.text_byte = b;
        t.text_start = s;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = sender_gaps ? $urandom_range(1, 6) : 0;
        end
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text <= t;
        do
            @(posedge clk);
        while (!text_ready);
        pending_results.push_back(predict_result(t));
        sent_count++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        text_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {REG_SEL_LSB{1'b0}}};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_PATTERN_0:      cfg_pattern[0] = v;
            REG_PATTERN_1:      cfg_pattern[1] = v;
            REG_PATTERN_2:      cfg_pattern[2] = v;
            REG_PATTERN_3:      cfg_pattern[3] = v;
            REG_PATTERN_LENGTH: cfg_length = v[LEN_W-1:0];
            REG_MAX_MISMATCHES: cfg_k = v[K_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] p0, input logic [63:0] p1,
                             input logic [63:0] p2, input logic [63:0] p3,
                             input logic [LEN_W-1:0] len, input logic [K_W-1:0] k);
        wait_idle();
        apb_write(REG_PATTERN_0, p0);
        apb_write(REG_PATTERN_1, p1);
        apb_write(REG_PATTERN_2, p2);
        apb_write(REG_PATTERN_3, p3);
        apb_write(REG_PATTERN_LENGTH, {$urandom, 27'($urandom), len});
        apb_write(REG_MAX_MISMATCHES, {$urandom, 29'($urandom), k});
    endtask

    // Bytes before the first text_start belong to a text that began at reset.
    task automatic test_reset_state();
        send_text(8'h55, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        send_text(8'h00, 1'b0);
    endtask

    task automatic test_exact_and_substitution();
        configure(64'h0000_0000_00FF_00FF, '0, '0, '0, 5'd3, 3'd0);
        send_text(8'hFF, 1'b1);
        send_text(8'h00, 1'b0);
        send_text(8'h12, 1'b0);
        send_text(8'hFF, 1'b1);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        wait_idle();
        apb_write(REG_MAX_MISMATCHES, 64'd1);
        send_text(8'h01, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h07, 1'b0);
        send_text(8'hFF, 1'b0);
    endtask

    // The mismatch limit changes in the middle of a text.
    task automatic test_limit_change_in_text();
        wait_idle();
        apb_write(REG_MAX_MISMATCHES, 64'd0);
        send_text(8'hFF, 1'b1);
        send_text(8'h11, 1'b0);
        wait_idle();
        apb_write(REG_MAX_MISMATCHES, 64'd1);
        send_text(8'hFF, 1'b0);
    endtask

    task automatic test_empty_pattern();
        wait_idle();
        apb_write(REG_PATTERN_LENGTH, 64'd0);
        send_text(8'hAB, 1'b1);
        send_text(8'hCD, 1'b0);
        send_text(8'h00, 1'b1);
    endtask

    task automatic send_search_text();
        logic [BYTE_W-1:0] text_buf [0:127];
        int m;
        int len_t;
        int at;
        int subs;
        int idx;
        m = int'(cfg_length);
        len_t = m + $urandom_range(0, m + 8);
        at = $urandom_range(0, len_t - m);
        subs = $urandom_range(0, int'(cfg_k) + 2);
        for (int i = 0; i < len_t; i++)
            text_buf[i] = small_alpha ? alpha_base + BYTE_W'($urandom_range(0, 3))
                                      : BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < m; i++)
            text_buf[at + i] = pattern_byte(i);
        repeat (subs)
        begin
            idx = at + $urandom_range(0, m - 1);
            text_buf[idx] = text_buf[idx] ^ BYTE_W'($urandom_range(1, 255));
        end
        for (int i = 0; i < len_t; i++)
            send_text(text_buf[i], i == 0);
    endtask

    task automatic test_random_search();
        logic [63:0]      p [0:3];
        logic [LEN_W-1:0] len;
        logic [K_W-1:0]   k;
        int               phase_start;
        bit               paused;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:       begin len = 5'd1;  k = 3'd0; end
                1:       begin len = 5'd31; k = 3'd7; end
                2:       begin len = 5'd31; k = 3'd0; end
                3:       begin len = 5'd1;  k = 3'd7; end
                4:       begin len = 5'd5;  k = 3'd2; end
                default: begin len = LEN_W'($urandom_range(1, 12)); k = K_W'($urandom_range(0, 7)); end
            endcase
            small_alpha = (ph % 3) != 2;
            sender_gaps = ph != 4;
            receiver_stalls = ph != 6;
            case ($urandom_range(0, 2))
                0:       alpha_base = 8'd0;
                1:       alpha_base = 8'd252;
                default: alpha_base = BYTE_W'($urandom_range(0, 252));
            endcase
            for (int r = 0; r < 4; r++)
                for (int b = 0; b < 8; b++)
                    p[r][b * 8 +: 8] = small_alpha ? alpha_base + BYTE_W'($urandom_range(0, 3))
                                                   : BYTE_W'($urandom_range(0, 255));
            configure(p[0], p[1], p[2], p[3], len, k);
            if (ph == 2)
                hold_request = 150;
            phase_start = sent_count;
            paused = 1'b0;
            while (sent_count - phase_start < 92)
            begin
                if (ph == 5 && !paused && sent_count - phase_start >= 46)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 10))
                        send_text(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                else
                    send_search_text();
            end
        end
    endtask

    initial
    begin
        for (int r = 0; r < PATTERN_REGS; r++)
            cfg_pattern[r] = '0;
        cfg_length = 5'd1;
        cfg_k = 3'd0;
        clear_text_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        test_reset_state();
        test_exact_and_substitution();
        test_limit_change_in_text();
        test_empty_pattern();
        test_random_search();
        wait_idle();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("bitap_hamming_search_top test passed");
        else
            $display("bitap_hamming_search_top test failed");
        $finish;
    end

endmodule
